// ===== src/kwl_pkg.sv =====
`default_nettype none

package kwl_pkg;

  localparam int KIND_W = 5;
  localparam int POS_W = 16;
  localparam int LEN_W = 8;
  localparam int KW_COUNT = 12;
  localparam int KW_BYTES = 9;
  localparam int QUEUE_DEPTH = 4;

  typedef logic [KIND_W-1:0] kind_t;

  localparam kind_t KIND_IDENT  = 5'd12;
  localparam kind_t KIND_LPAREN = 5'd13;
  localparam kind_t KIND_RPAREN = 5'd14;
  localparam kind_t KIND_LBRACE = 5'd15;
  localparam kind_t KIND_RBRACE = 5'd16;
  localparam kind_t KIND_COMMA  = 5'd17;
  localparam kind_t KIND_ARROW  = 5'd18;
  localparam kind_t KIND_EOF    = 5'd19;
  localparam kind_t KIND_ERROR  = 5'd20;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // keyword text, first character in the top byte, zero padded
  localparam logic [KW_BYTES*8-1:0] KW_TEXT [KW_COUNT] = '{
    {"none", 40'd0},
    {"nil", 48'd0},
    "undefined",
    {"null", 40'd0},
    {"function", 8'd0},
    {"if", 56'd0},
    {"else", 40'd0},
    {"match", 32'd0},
    {"case", 40'd0},
    {"default", 16'd0},
    {"pair", 40'd0},
    {"list", 40'd0}
  };

  localparam logic [LEN_W-1:0] KW_LEN [KW_COUNT] = '{
    8'd4, 8'd3, 8'd9, 8'd4, 8'd8, 8'd2, 8'd4, 8'd5, 8'd4, 8'd7, 8'd4, 8'd4
  };

  typedef struct packed {
    logic             last;
    logic [LEN_W-1:0] length;
    logic [POS_W-1:0] column;
    logic [POS_W-1:0] line;
    kind_t            kind;
  } tok_t;

  typedef struct packed {
    logic [1:0] count;
    tok_t       first;
    tok_t       second;
  } push_t;

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_word_char(logic [7:0] c);
    return is_alpha(c) || (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR;
  endfunction

  function automatic logic is_punct(logic [7:0] c);
    return c == CH_LPAREN || c == CH_RPAREN || c == CH_LBRACE || c == CH_RBRACE ||
           c == CH_COMMA;
  endfunction

  function automatic kind_t punct_kind(logic [7:0] c);
    kind_t k;
    k = KIND_COMMA;
    if (c == CH_LPAREN) k = KIND_LPAREN;
    else if (c == CH_RPAREN) k = KIND_RPAREN;
    else if (c == CH_LBRACE) k = KIND_LBRACE;
    else if (c == CH_RBRACE) k = KIND_RBRACE;
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== src/kwl_match.sv =====
`default_nettype none

module kwl_match #(
  parameter int MAX_KEYWORD_LEN = 9
) (
  input  logic [7:0]                word_chars [MAX_KEYWORD_LEN],
  input  logic [kwl_pkg::LEN_W-1:0] word_len,
  output kwl_pkg::kind_t            kind
);

  logic [kwl_pkg::KW_COUNT-1:0] hit;

  always_comb begin
    for (int k = 0; k < kwl_pkg::KW_COUNT; k++) begin
      hit[k] = (word_len == kwl_pkg::KW_LEN[k]);
      for (int i = 0; i < kwl_pkg::KW_BYTES; i++) begin
        if (i < int'(kwl_pkg::KW_LEN[k]) &&
            word_chars[i] != kwl_pkg::KW_TEXT[k][kwl_pkg::KW_BYTES*8-1-8*i -: 8]) begin
          hit[k] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    kind = kwl_pkg::KIND_IDENT;
    for (int k = kwl_pkg::KW_COUNT - 1; k >= 0; k--) begin
      if (hit[k]) kind = kwl_pkg::KIND_W'(k);
    end
  end

endmodule

`default_nettype wire

// ===== src/kwl_core.sv =====
`default_nettype none

module kwl_core #(
  parameter int LINE_BITS       = 16,
  parameter int COLUMN_BITS     = 16,
  parameter int MAX_KEYWORD_LEN = 9
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_char,
  input  logic               in_end,
  input  logic               room,
  output kwl_pkg::push_t     push
);

  localparam int IDX_BITS = $clog2(MAX_KEYWORD_LEN);
  localparam int LW = (LINE_BITS > kwl_pkg::POS_W) ? LINE_BITS : kwl_pkg::POS_W;
  localparam int CW = (COLUMN_BITS > kwl_pkg::POS_W) ? COLUMN_BITS : kwl_pkg::POS_W;
  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
  localparam logic [COLUMN_BITS-1:0] COL_MAX = {COLUMN_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
  localparam logic [COLUMN_BITS-1:0] COL_ONE = COLUMN_BITS'(1);
  localparam logic [kwl_pkg::LEN_W-1:0] LEN_MAX = {kwl_pkg::LEN_W{1'b1}};

  function automatic logic [kwl_pkg::POS_W-1:0] line_out(logic [LINE_BITS-1:0] v);
    logic [LW-1:0] e;
    e = LW'(v);
    return (e > LW'(16'hFFFF)) ? 16'hFFFF : e[kwl_pkg::POS_W-1:0];
  endfunction

  function automatic logic [kwl_pkg::POS_W-1:0] col_out(logic [COLUMN_BITS-1:0] v);
    logic [CW-1:0] e;
    e = CW'(v);
    return (e > CW'(16'hFFFF)) ? 16'hFFFF : e[kwl_pkg::POS_W-1:0];
  endfunction

  function automatic kwl_pkg::tok_t mk(kwl_pkg::kind_t k, logic [LINE_BITS-1:0] l,
                                       logic [COLUMN_BITS-1:0] c,
                                       logic [kwl_pkg::LEN_W-1:0] n);
    kwl_pkg::tok_t t;
    t.last   = 1'b0;
    t.kind   = k;
    t.line   = line_out(l);
    t.column = col_out(c);
    t.length = n;
    return t;
  endfunction

  // input register
  logic       item_valid;
  logic [7:0] item_char;
  logic       item_end;
  logic       adv;

  // lexer state
  logic [LINE_BITS-1:0]        line_count, line_count_next;
  logic [COLUMN_BITS-1:0]      column_count, column_count_next;
  logic [LINE_BITS-1:0]        prev_end_line, prev_end_line_next;
  logic [COLUMN_BITS-1:0]      prev_end_column, prev_end_column_next;
  logic [kwl_pkg::LEN_W-1:0]   word_len, word_len_next;
  logic                        in_word, in_word_next;
  logic                        dash_pending, dash_pending_next;
  logic                        draining, draining_next;
  logic [7:0]                  word_chars [MAX_KEYWORD_LEN];

  logic                        wr_en;
  logic [IDX_BITS-1:0]         wr_idx;
  kwl_pkg::kind_t              word_kind;
  logic [LINE_BITS-1:0]        line1;
  logic [COLUMN_BITS-1:0]      col1, col2;
  kwl_pkg::tok_t               t0, t1, extra, eof_tok;
  logic                        extra_valid;
  logic [1:0]                  cnt;

  assign adv      = item_valid && room;
  assign in_ready = !item_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_char <= in_char;
      item_end  <= in_end;
    end
  end

  kwl_match #(
    .MAX_KEYWORD_LEN(MAX_KEYWORD_LEN)
  ) u_match (
    .word_chars(word_chars),
    .word_len(word_len),
    .kind(word_kind)
  );

  assign line1 = (line_count == LINE_MAX) ? line_count : line_count + LINE_ONE;
  assign col1  = (column_count == COL_MAX) ? column_count : column_count + COL_ONE;
  assign col2  = (column_count >= COL_MAX - COL_ONE) ? COL_MAX :
                 column_count + COLUMN_BITS'(2);

  always_comb begin
    line_count_next      = line_count;
    column_count_next    = column_count;
    prev_end_line_next   = prev_end_line;
    prev_end_column_next = prev_end_column;
    word_len_next        = word_len;
    in_word_next         = in_word;
    dash_pending_next    = dash_pending;
    draining_next        = draining;
    wr_en                = 1'b0;
    wr_idx               = word_len[IDX_BITS-1:0];
    t0                   = '0;
    t1                   = '0;
    extra                = '0;
    extra_valid          = 1'b0;
    eof_tok              = '0;
    cnt                  = 2'd0;

    if (adv) begin
      if (item_end) begin
        if (!draining && in_word) begin
          t0      = mk(word_kind, prev_end_line, prev_end_column, word_len);
          cnt     = 2'd1;
          eof_tok = mk(kwl_pkg::KIND_EOF, line_count, column_count, '0);
        end else if (!draining && dash_pending) begin
          t0      = mk(kwl_pkg::KIND_ERROR, line_count, column_count, 8'd1);
          cnt     = 2'd1;
          eof_tok = mk(kwl_pkg::KIND_EOF, prev_end_line, prev_end_column, '0);
        end else begin
          eof_tok = mk(kwl_pkg::KIND_EOF, prev_end_line, prev_end_column, '0);
        end
        if (cnt == 2'd0) begin
          t0  = eof_tok;
          cnt = 2'd1;
        end else begin
          t1  = eof_tok;
          cnt = 2'd2;
        end
        line_count_next      = LINE_ONE;
        column_count_next    = COL_ONE;
        prev_end_line_next   = LINE_ONE;
        prev_end_column_next = COL_ONE;
        word_len_next        = '0;
        in_word_next         = 1'b0;
        dash_pending_next    = 1'b0;
        draining_next        = 1'b0;
      end else if (draining) begin
        cnt = 2'd0;
      end else if (dash_pending) begin
        dash_pending_next = 1'b0;
        cnt               = 2'd1;
        if (item_char == kwl_pkg::CH_GT) begin
          t0                   = mk(kwl_pkg::KIND_ARROW, prev_end_line, prev_end_column,
                                    8'd2);
          column_count_next    = col2;
          prev_end_line_next   = line_count;
          prev_end_column_next = col2;
        end else begin
          t0            = mk(kwl_pkg::KIND_ERROR, line_count, column_count, 8'd1);
          draining_next = 1'b1;
        end
      end else if (in_word && kwl_pkg::is_word_char(item_char)) begin
        wr_en             = (word_len < kwl_pkg::LEN_W'(MAX_KEYWORD_LEN));
        word_len_next     = (word_len == LEN_MAX) ? word_len : word_len + 8'd1;
        column_count_next = col1;
      end else begin
        if (in_word) begin
          t0                   = mk(word_kind, prev_end_line, prev_end_column, word_len);
          cnt                  = 2'd1;
          in_word_next         = 1'b0;
          prev_end_line_next   = line_count;
          prev_end_column_next = column_count;
        end
        if (kwl_pkg::is_blank(item_char)) begin
          column_count_next = col1;
        end else if (item_char == kwl_pkg::CH_LF) begin
          line_count_next   = line1;
          column_count_next = COL_ONE;
        end else if (kwl_pkg::is_punct(item_char)) begin
          extra_valid = 1'b1;
          // position is the previous end, already moved up if a word just closed
          if (in_word) begin
            extra = mk(kwl_pkg::punct_kind(item_char), line_count, column_count, 8'd1);
          end else begin
            extra = mk(kwl_pkg::punct_kind(item_char), prev_end_line, prev_end_column,
                       8'd1);
          end
          column_count_next    = col1;
          prev_end_line_next   = line_count;
          prev_end_column_next = col1;
        end else if (item_char == kwl_pkg::CH_DASH) begin
          dash_pending_next = 1'b1;
        end else if (kwl_pkg::is_alpha(item_char) || item_char == kwl_pkg::CH_UNDER) begin
          in_word_next      = 1'b1;
          wr_en             = 1'b1;
          wr_idx            = '0;
          word_len_next     = 8'd1;
          column_count_next = col1;
        end else begin
          extra_valid   = 1'b1;
          extra         = mk(kwl_pkg::KIND_ERROR, line_count, column_count, 8'd1);
          draining_next = 1'b1;
        end
        if (extra_valid) begin
          if (in_word) begin
            t1  = extra;
            cnt = 2'd2;
          end else begin
            t0  = extra;
            cnt = 2'd1;
          end
        end
      end
    end

    t0.last = (cnt == 2'd1);
    t1.last = 1'b1;
  end

  assign push.count  = cnt;
  assign push.first  = t0;
  assign push.second = t1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count      <= LINE_ONE;
      column_count    <= COL_ONE;
      prev_end_line   <= LINE_ONE;
      prev_end_column <= COL_ONE;
      word_len        <= '0;
      in_word         <= 1'b0;
      dash_pending    <= 1'b0;
      draining        <= 1'b0;
    end else begin
      line_count      <= line_count_next;
      column_count    <= column_count_next;
      prev_end_line   <= prev_end_line_next;
      prev_end_column <= prev_end_column_next;
      word_len        <= word_len_next;
      in_word         <= in_word_next;
      dash_pending    <= dash_pending_next;
      draining        <= draining_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      word_chars[wr_idx] <= item_char;
    end
  end

endmodule

`default_nettype wire

// ===== src/kwl_queue.sv =====
`default_nettype none

module kwl_queue (
  input  logic           clk,
  input  logic           rst,
  input  kwl_pkg::push_t push,
  output logic           room,
  output logic           out_valid,
  input  logic           out_ready,
  output kwl_pkg::tok_t  out_tok
);

  localparam int PTR_W = $clog2(kwl_pkg::QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  kwl_pkg::tok_t      entries [kwl_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               pop;
  logic [PTR_W-1:0]   wr_ptr1;

  assign pop       = out_valid && out_ready;
  assign out_valid = (count != '0);
  assign out_tok   = entries[rd_ptr];
  assign room      = (count <= CNT_W'(kwl_pkg::QUEUE_DEPTH - 2));
  assign wr_ptr1   = wr_ptr + PTR_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + CNT_W'(push.count) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      entries[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      entries[wr_ptr1] <= push.second;
    end
  end

endmodule

`default_nettype wire

// ===== src/keyword_token_lexer.sv =====
// channel  dir  tdata (low bit up)                                  tlast
// s_       in   char_code[7:0]                                      end_of_input
// m_       out  token_kind[4:0] token_line[20:5] token_column[36:21]  last_of_run
//               word_length[44:37] zero[47:45]
//
// One source byte per cycle while the result queue has room; the path is the
// input register, one pass of lexing logic, result queue; an item may push two.
// s_tready drops only when the four-entry result queue lacks room for two tokens.
// rst is synchronous and clears all control state; the word store is not cleared.
`default_nettype none

module keyword_token_lexer #(
  parameter int LINE_BITS       = 16,
  parameter int COLUMN_BITS     = 16,
  parameter int MAX_KEYWORD_LEN = 9
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // char_code
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // token_kind, token_line, token_column, word_length
  output logic        m_tlast
);

  kwl_pkg::push_t push;
  kwl_pkg::tok_t  head;
  logic           room;

  kwl_core #(
    .LINE_BITS(LINE_BITS),
    .COLUMN_BITS(COLUMN_BITS),
    .MAX_KEYWORD_LEN(MAX_KEYWORD_LEN)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .in_char(s_tdata),
    .in_end(s_tlast),
    .room(room),
    .push(push)
  );

  kwl_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .room(room),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_tok(head)
  );

  assign m_tdata = {3'b000, head.length, head.column, head.line, head.kind};
  assign m_tlast = head.last;

endmodule

`default_nettype wire
